### src/lrucc_pkg.sv
// Shared constants and types for the least-recently-used key cache.
// Used by the sequencer, the fold stage and the top level; no dependencies.
package lrucc_pkg;

    localparam int KEY_W    = 64;
    localparam int CFG_W    = 6;
    localparam int COST_W   = 3;
    localparam int TOTAL_W  = 32;
    localparam int WAYS_DEF = 32;
    localparam int BYTES    = KEY_W / 8;

    localparam logic [COST_W-1:0] COST_HIT  = 3'd1;
    localparam logic [COST_W-1:0] COST_MISS = 3'd5;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // One result beat; hit sits in the lowest bit.
    typedef struct packed {
        logic [TOTAL_W-1:0] total_cost;
        logic [COST_W-1:0]  access_cost;
        logic               hit;
    } lrucc_result_t;

endpackage

### src/lru_cache_hit_miss_cost_top.sv
// Top level of the least-recently-used key cache with running access cost.
// Depends on lrucc_pkg, lrucc_fold, lrucc_ctrl (which holds lrucc_ram).
//
// Channel   Signals                         Contents
// cfg       cfg_we, cfg_wdata[5:0]          cache_size, written when cfg_we is high
// s_axis    tvalid, tready, tdata[63:0]     key
// m_axis    tvalid, tready, tdata[39:0]     hit, access_cost, total_cost
//
// An item holds the sequencer while it compares m stored keys and takes s move steps
// from the hit or eviction point to the end of the list (a miss with room steps over
// the whole list); with a zero cache size it does neither and only updates the total.
// Every compare and every move waits for one registered read of the key store.
// Reset clears the size register, the fill count, the running total and both
// handshakes; the key store itself is not cleared, as only filled entries are read.
// A result waits in the output register while the next beat is taken; the
// sequencer holds its finished result only while that register is still full.
module lru_cache_hit_miss_cost_top
    import lrucc_pkg::*;
#(
    parameter int WAYS = WAYS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,      // cache_size
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [63:0]      s_axis_tdata,   // [63:0] key
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [39:0]      m_axis_tdata    // [0] hit, [3:1] access_cost, [35:4] total_cost
);

    logic [CFG_W-1:0] cache_size_reg;
    logic             m_valid_reg;
    lrucc_result_t    m_res_reg;

    logic [KEY_W-1:0] key_folded;
    logic             ctrl_idle;
    logic             res_valid;
    logic             res_ack;
    lrucc_result_t    res;

    lrucc_fold u_fold (
        .key_in  (s_axis_tdata),
        .key_out (key_folded)
    );

    lrucc_ctrl #(
        .WAYS (WAYS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (s_axis_tvalid && s_axis_tready),
        .key        (key_folded),
        .cache_size (cache_size_reg),
        .idle       (ctrl_idle),
        .res_valid  (res_valid),
        .res_ack    (res_ack),
        .res        (res)
    );

    assign s_axis_tready = ctrl_idle;
    assign res_ack       = res_valid && (!m_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cache_size_reg <= '0;
            m_valid_reg    <= 1'b0;
            m_res_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                cache_size_reg <= cfg_wdata;
            end
            if (res_ack)
            begin
                m_valid_reg <= 1'b1;
                m_res_reg   <= res;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'b0000, m_res_reg};

endmodule

### src/lrucc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; contents are not cleared by reset.
module lrucc_ram #(
    parameter int W = 64,
    parameter int D = 32,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [W-1:0]  wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [W-1:0]  rd_data
);

    logic [W-1:0] mem [D];
    logic [W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### src/lrucc_fold.sv
// Folds the upper-case ASCII bytes of a packed key to lower case.
// Depends on lrucc_pkg.
module lrucc_fold
    import lrucc_pkg::*;
(
    input  logic [KEY_W-1:0] key_in,
    output logic [KEY_W-1:0] key_out
);

    always_comb
    begin
        logic [7:0] c;
        key_out = '0;
        for (int b = 0; b < BYTES; b++)
        begin
            c = key_in[b*8 +: 8];
            if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
            begin
                c = c + CASE_OFFSET;
            end
            key_out[b*8 +: 8] = c;
        end
    end

endmodule

### src/lrucc_ctrl.sv
// Sequencer for the cache: searches the stored keys one read at a time, then
// moves entries down and writes the new key. Depends on lrucc_pkg, lrucc_ram.
module lrucc_ctrl
    import lrucc_pkg::*;
#(
    parameter int WAYS = WAYS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [KEY_W-1:0]   key,
    input  logic [CFG_W-1:0]   cache_size,
    output logic               idle,
    output logic               res_valid,
    input  logic               res_ack,
    output lrucc_result_t      res
);

    localparam int AW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CW = $clog2(WAYS + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_MISS,
        ST_SHCHK,
        ST_SHRD,
        ST_SHWR,
        ST_INS,
        ST_FIN,
        ST_DONE
    } state_t;

    state_t             state_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [CW-1:0]      fill_reg;
    logic [CW-1:0]      idx_reg;
    logic [CW-1:0]      dist_reg;
    logic [CW-1:0]      end_reg;
    logic               hit_reg;
    logic [TOTAL_W-1:0] total_reg;

    logic [CW-1:0]      limit;
    logic [CW-1:0]      addr_sum;
    logic [COST_W-1:0]  cost;
    logic [TOTAL_W:0]   total_sum;
    logic               ram_we;
    logic [AW-1:0]      ram_wr_addr;
    logic [KEY_W-1:0]   ram_wr_data;
    logic [KEY_W-1:0]   ram_rd_data;

    assign limit = (int'(cache_size) > WAYS) ? CW'(WAYS) : CW'(cache_size);

    // One index adder serves both the search read and the move read.
    assign addr_sum = idx_reg + ((state_reg == ST_SHRD) ? dist_reg : '0);

    assign cost      = hit_reg ? COST_HIT : COST_MISS;
    assign total_sum = {1'b0, total_reg} + (TOTAL_W + 1)'(cost);

    assign ram_we      = (state_reg == ST_SHWR) || (state_reg == ST_INS);
    assign ram_wr_addr = (state_reg == ST_INS) ? end_reg[AW-1:0] : idx_reg[AW-1:0];
    assign ram_wr_data = (state_reg == ST_INS) ? key_reg : ram_rd_data;

    lrucc_ram #(
        .W (KEY_W),
        .D (WAYS)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (addr_sum[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            key_reg   <= '0;
            fill_reg  <= '0;
            idx_reg   <= '0;
            dist_reg  <= '0;
            end_reg   <= '0;
            hit_reg   <= 1'b0;
            total_reg <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        key_reg <= key;
                        idx_reg <= '0;
                        hit_reg <= 1'b0;
                        if (limit == '0)
                        begin
                            // Zero size: a miss that leaves the list alone.
                            state_reg <= ST_FIN;
                        end
                        else if (fill_reg == '0)
                        begin
                            state_reg <= ST_MISS;
                        end
                        else
                        begin
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_CMP;
                end
                ST_CMP:
                begin
                    if (ram_rd_data == key_reg)
                    begin
                        // Close the gap at the hit position and append at the end.
                        hit_reg   <= 1'b1;
                        dist_reg  <= CW'(1);
                        end_reg   <= fill_reg - CW'(1);
                        state_reg <= ST_SHCHK;
                    end
                    else if ((idx_reg + CW'(1)) == fill_reg)
                    begin
                        state_reg <= ST_MISS;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= ST_READ;
                    end
                end
                ST_MISS:
                begin
                    // Evict enough of the oldest entries to make room for one.
                    idx_reg <= '0;
                    if (fill_reg >= limit)
                    begin
                        dist_reg <= fill_reg - limit + CW'(1);
                        end_reg  <= limit - CW'(1);
                    end
                    else
                    begin
                        dist_reg <= '0;
                        end_reg  <= fill_reg;
                    end
                    state_reg <= ST_SHCHK;
                end
                ST_SHCHK:
                begin
                    state_reg <= (idx_reg < end_reg) ? ST_SHRD : ST_INS;
                end
                ST_SHRD:
                begin
                    state_reg <= ST_SHWR;
                end
                ST_SHWR:
                begin
                    idx_reg   <= idx_reg + CW'(1);
                    state_reg <= ST_SHCHK;
                end
                ST_INS:
                begin
                    fill_reg  <= end_reg + CW'(1);
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    total_reg <= total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (res_ack)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign idle             = (state_reg == ST_IDLE);
    assign res_valid        = (state_reg == ST_DONE);
    assign res.hit          = hit_reg;
    assign res.access_cost  = cost;
    assign res.total_cost   = total_reg;

endmodule

### src/lrucc_chk.sv
// Port-level checker for the cache top level, attached by the bind below.
// Depends on lru_cache_hit_miss_cost_top only through its ports.
module lrucc_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    logic [1:0]  pend_reg;
    logic [31:0] last_total_reg;
    logic        seen_reg;
    logic        s_beat;
    logic        m_beat;

    assign s_beat = s_axis_tvalid && s_axis_tready;
    assign m_beat = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg       <= '0;
            last_total_reg <= '0;
            seen_reg       <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_reg + {1'b0, s_beat} - {1'b0, m_beat};
            if (m_beat)
            begin
                last_total_reg <= m_axis_tdata[35:4];
                seen_reg       <= 1'b1;
            end
        end
    end

    // A held result must not change while the sink stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Taking a key starts the sequencer, which then is busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_beat |=> !s_axis_tready)
        else $error("ready stayed high after a key was taken");

    // Hit flag and cost agree, and the padding is zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[39:36] == 4'b0000 &&
            ((m_axis_tdata[0] && m_axis_tdata[3:1] == 3'd1) ||
             (!m_axis_tdata[0] && m_axis_tdata[3:1] == 3'd5)))
        else $error("hit flag and cost disagree");

    // The running total never falls from one result to the next.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_beat && seen_reg |-> m_axis_tdata[35:4] >= last_total_reg)
        else $error("running total fell");

    // At most one key in work and one result waiting; no result without a key.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg <= 2'd2) && (!m_axis_tvalid || pend_reg != 2'd0) &&
            (!s_beat || pend_reg <= 2'd1))
        else $error("keys and results out of step");

endmodule

bind lru_cache_hit_miss_cost_top lrucc_chk u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### verif/tb_lru_cache_hit_miss_cost_top.sv
// Self-checking testbench for lru_cache_hit_miss_cost_top: keys go in on the slave stream,
// a local LRU cache model predicts hit, access cost and running total for every beat.
// Depends on lrucc_pkg and the RTL of the block only.
module tb_lru_cache_hit_miss_cost_top;
    import lrucc_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int POOL_MAX    = 48;
    localparam int NUM_PHASES  = 12;
    localparam int PHASE_KEYS  = 96;

    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic             cfg_we        = 1'b0;
    logic [CFG_W-1:0] cfg_wdata     = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [63:0]      s_axis_tdata  = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [39:0]      m_axis_tdata;

    // Keys waiting to be driven and results waiting to be seen.
    logic [KEY_W-1:0] pending_keys[$];
    lrucc_result_t    expected_results[$];

    // Cache model: lines[0] is the oldest entry.
    logic [KEY_W-1:0]   lines[WAYS_DEF];
    int                 line_count   = 0;
    logic [TOTAL_W-1:0] running_cost = '0;
    int                 size_setting = 0;

    logic [KEY_W-1:0] key_pool[POOL_MAX];
    int               pool_len = 4;

    int send_idle_pct  = 20;
    int recv_stall_pct = 66;
    int errors         = 0;
    int hits_seen      = 0;
    int misses_seen    = 0;
    int size_writes    = 0;
    int cycles         = 0;

    lrucc_result_t got;

    lru_cache_hit_miss_cost_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic void queue_key(logic [KEY_W-1:0] k);
        pending_keys.insert(pending_keys.size(), k);
    endfunction

    function automatic void drop_line(int pos);
        for (int i = pos; i + 1 < line_count; i++)
            lines[i] = lines[i + 1];
        line_count--;
    endfunction

    // Looks one key up in the model, updates its state and returns the expected beat.
    function automatic lrucc_result_t cache_access(logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0]   folded;
        logic [7:0]         ch;
        logic [COST_W-1:0]  cost;
        int                 limit;
        int                 pos;
        bit                 found;
        lrucc_result_t      res;
        folded = '0;
        for (int b = 0; b < BYTES; b++)
        begin
            ch = raw[b*8 +: 8];
            if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z)
                ch = ch + CASE_OFFSET;
            folded[b*8 +: 8] = ch;
        end
        limit = (size_setting > WAYS_DEF) ? WAYS_DEF : size_setting;
        found = 1'b0;
        pos   = 0;
        if (limit != 0)
        begin
            for (int i = 0; i < line_count; i++)
            begin
                if (!found && lines[i] == folded)
                begin
                    found = 1'b1;
                    pos   = i;
                end
            end
            if (found)
                drop_line(pos);
            else
                while (line_count >= limit && line_count > 0)
                    drop_line(0);
            lines[line_count] = folded;
            line_count++;
        end
        cost = found ? COST_HIT : COST_MISS;
        if (running_cost > {TOTAL_W{1'b1}} - TOTAL_W'(cost))
            running_cost = {TOTAL_W{1'b1}};
        else
            running_cost = running_cost + TOTAL_W'(cost);
        if (found)
            hits_seen++;
        else
            misses_seen++;
        res.hit         = found;
        res.access_cost = cost;
        res.total_cost  = running_cost;
        return res;
    endfunction

    // Mostly keys from a small pool with random letter case, some fully random words.
    function automatic logic [KEY_W-1:0] make_key();
        logic [KEY_W-1:0] k;
        if ($urandom_range(99) < 12)
            k = {$urandom, $urandom};
        else
        begin
            k = key_pool[$urandom_range(pool_len - 1)];
            for (int b = 0; b < BYTES; b++)
                if (k[b*8 +: 8] >= 8'h61 && k[b*8 +: 8] <= 8'h7A && $urandom_range(1) == 1)
                    k[b*8 +: 8] = k[b*8 +: 8] - CASE_OFFSET;
        end
        return k;
    endfunction

    function automatic void fill_pool(int len);
        int n;
        pool_len = len;
        for (int p = 0; p < len; p++)
        begin
            key_pool[p] = '0;
            n = $urandom_range(1, BYTES);
            for (int b = 0; b < n; b++)
                key_pool[p][b*8 +: 8] = ($urandom_range(99) < 85) ?
                    8'($urandom_range(8'h61, 8'h7A)) : 8'($urandom_range(1, 255));
        end
    endfunction

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_keys.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_cache_size(int value);
        wait_idle();
        @(posedge clk);
        cfg_we       <= 1'b1;
        cfg_wdata    <= CFG_W'(value);
        size_setting = value;
        size_writes++;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Driver: once the previous beat has gone, a pending key is offered unless a random idle gap is drawn.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_results.insert(expected_results.size(), cache_access(s_axis_tdata));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_keys.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_keys.pop_front();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result beat against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[35:0];
                if (expected_results.size() == 0)
                begin
                    $error("result beat with no prediction waiting: %h", m_axis_tdata);
                    errors++;
                end
                else
                begin
                    if (got.hit !== expected_results[0].hit)
                    begin
                        $error("hit: expected %0d, got %0d", expected_results[0].hit, got.hit);
                        errors++;
                    end
                    if (got.access_cost !== expected_results[0].access_cost)
                    begin
                        $error("access_cost: expected %0d, got %0d",
                               expected_results[0].access_cost, got.access_cost);
                        errors++;
                    end
                    if (got.total_cost !== expected_results[0].total_cost)
                    begin
                        $error("total_cost: expected %0d, got %0d",
                               expected_results[0].total_cost, got.total_cost);
                        errors++;
                    end
                    void'(expected_results.pop_front());
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_results.size());
            $display("lru_cache_hit_miss_cost_top: mismatch");
            $finish;
        end
    end

    initial
    begin
        int phase_size[NUM_PHASES];
        int limit;
        phase_size = '{1, 32, 63, 5, 0, 17, 40, 3, 2, 12, 32, 8};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: eviction order, a hit moving to the newest slot,
        // case folding at the letter boundaries and a zero-size cache leaving the list alone.
        set_cache_size(2);
        queue_key('0);
        queue_key({KEY_W{1'b1}});
        queue_key('0);
        queue_key("ABCDEFGH");
        queue_key("abcdefgh");
        queue_key({KEY_W{1'b1}});
        queue_key('0);
        set_cache_size(0);
        queue_key("abcdefgh");
        queue_key('0);
        set_cache_size(2);
        queue_key("AbCdEfGh");
        queue_key(64'h7B7A_6160_5B5A_4140);
        queue_key(64'h7B7A_6160_5B7A_6140);
        queue_key(64'h7B5A_6140_5B7A_6160);
        queue_key("x");

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph == 4)
            begin
                send_idle_pct  = 66;
                recv_stall_pct = 20;
            end
            else if (ph == 8)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            set_cache_size(phase_size[ph]);
            limit = (phase_size[ph] > WAYS_DEF) ? WAYS_DEF : phase_size[ph];
            fill_pool((limit + limit / 2 + 3 > POOL_MAX) ? POOL_MAX : limit + limit / 2 + 3);
            for (int n = 0; n < PHASE_KEYS; n++)
            begin
                // Once in the run the sender holds back until the block has drained.
                if (ph == 1 && n == PHASE_KEYS / 2)
                begin
                    wait_idle();
                    @(negedge clk);
                end
                queue_key(make_key());
            end
        end

        wait_idle();
        repeat (140) @(negedge clk);
        $display("Checked %0d key beats (%0d hits, %0d misses) across %0d cache size writes,",
                 hits_seen + misses_seen, hits_seen, misses_seen, size_writes);
        $display("sizes from 0 to 63 including shrinks below the fill count, under mixed stalls.");
        if (errors == 0)
            $display("lru_cache_hit_miss_cost_top: match");
        else
            $display("lru_cache_hit_miss_cost_top: mismatch");
        $finish;
    end

endmodule

### filelist.f
src/lrucc_pkg.sv
src/lrucc_ram.sv
src/lrucc_fold.sv
src/lrucc_ctrl.sv
src/lru_cache_hit_miss_cost_top.sv
src/lrucc_chk.sv
verif/tb_lru_cache_hit_miss_cost_top.sv
